/* design/ldpcrow_pkg.sv */
`default_nettype none

package ldpcrow_pkg;

    localparam int MAX_DEGREE_DEF = 32;
    localparam int LLR_WIDTH_DEF  = 10;
    localparam int QUEUE_DEPTH    = 4;

    // Per-edge control that travels from the front end to the back end.
    typedef struct packed {
        logic keep;   // edge is inside the row's degree and gets buffered
        logic last;   // edge closes the row; row summary is valid
    } t_edge_ctl;

endpackage

`default_nettype wire

/* design/ldpcrow_front.sv */
`default_nettype none

module ldpcrow_front
    import ldpcrow_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int LLR_WIDTH  = LLR_WIDTH_DEF,
    localparam int MW = LLR_WIDTH - 1,
    localparam int AW = $clog2(MAX_DEGREE),
    localparam int CW = $clog2(MAX_DEGREE + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [LLR_WIDTH-1:0] i_posterior_llr,
    input  wire logic [LLR_WIDTH-1:0] i_old_check_msg,
    input  wire logic                 i_last_edge,
    input  wire logic                 i_full,
    output logic                      o_push,
    output t_edge_ctl                 o_ctl,
    output logic [LLR_WIDTH-1:0]      o_q,
    output logic [MW-1:0]             o_min1,
    output logic [MW-1:0]             o_min2,
    output logic [AW-1:0]             o_pos,
    output logic                      o_par,
    output logic [CW-1:0]             o_cnt
);

    localparam logic [LLR_WIDTH-1:0] MAXV = {1'b0, {MW{1'b1}}};
    localparam logic [LLR_WIDTH-1:0] MINV = {1'b1, {MW{1'b0}}};

    logic [MW-1:0] r_min1;
    logic [MW-1:0] r_min2;
    logic [AW-1:0] r_pos;
    logic          r_par;
    logic [CW-1:0] r_cnt;

    logic [MW-1:0] n_min1;
    logic [MW-1:0] n_min2;
    logic [AW-1:0] n_pos;
    logic          n_par;
    logic [CW-1:0] n_cnt;

    logic [LLR_WIDTH:0]   diff;
    logic [LLR_WIDTH-1:0] q;
    logic [LLR_WIDTH-1:0] neg_q;
    logic [MW-1:0]        mag;
    logic                 keep;
    logic                 accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign keep    = (r_cnt < CW'(MAX_DEGREE));

    assign diff = {i_posterior_llr[LLR_WIDTH-1], i_posterior_llr}
                - {i_old_check_msg[LLR_WIDTH-1], i_old_check_msg};

    always_comb begin
        if (diff[LLR_WIDTH] != diff[LLR_WIDTH-1]) begin
            q = diff[LLR_WIDTH] ? MINV : MAXV;
        end else begin
            q = diff[LLR_WIDTH-1:0];
        end
    end

    // The most negative value has no positive twin and saturates to the top.
    assign neg_q = '0 - q;
    always_comb begin
        if (q == MINV) begin
            mag = {MW{1'b1}};
        end else if (q[LLR_WIDTH-1]) begin
            mag = neg_q[MW-1:0];
        end else begin
            mag = q[MW-1:0];
        end
    end

    always_comb begin
        n_min1 = r_min1;
        n_min2 = r_min2;
        n_pos  = r_pos;
        n_par  = r_par;
        n_cnt  = r_cnt;
        if (keep) begin
            if (mag < r_min2) begin
                if (mag < r_min1) begin
                    n_min2 = r_min1;
                    n_min1 = mag;
                    n_pos  = r_cnt[AW-1:0];
                end else begin
                    n_min2 = mag;
                end
            end
            n_par = r_par ^ q[LLR_WIDTH-1];
            n_cnt = r_cnt + CW'(1);
        end
    end

    // Edges past the row's degree only matter when they close the row.
    assign o_push     = accept && (keep || i_last_edge);
    assign o_ctl.keep = keep;
    assign o_ctl.last = i_last_edge;
    assign o_q        = q;
    assign o_min1     = n_min1;
    assign o_min2     = n_min2;
    assign o_pos      = n_pos;
    assign o_par      = n_par;
    assign o_cnt      = n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min1 <= {MW{1'b1}};
            r_min2 <= {MW{1'b1}};
            r_pos  <= '0;
            r_par  <= 1'b0;
            r_cnt  <= '0;
        end else if (accept) begin
            if (i_last_edge) begin
                r_min1 <= {MW{1'b1}};
                r_min2 <= {MW{1'b1}};
                r_pos  <= '0;
                r_par  <= 1'b0;
                r_cnt  <= '0;
            end else begin
                r_min1 <= n_min1;
                r_min2 <= n_min2;
                r_pos  <= n_pos;
                r_par  <= n_par;
                r_cnt  <= n_cnt;
            end
        end
    end

endmodule

`default_nettype wire

/* design/ldpcrow_queue.sv */
`default_nettype none

module ldpcrow_queue
    import ldpcrow_pkg::*;
#(
    parameter int DW    = 8,
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int NW = $clog2(DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [DW-1:0] i_wdata,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic [DW-1:0]      o_rdata,
    output logic               o_empty
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [NW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + NW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && i_push && !i_pop |=> o_full && $stable(r_wr_ptr))
        else $error("queue write pointer moved while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty && !i_push |=> o_empty)
        else $error("queue became non-empty without a push");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(DEPTH))
        else $error("queue count exceeds its depth");

endmodule

`default_nettype wire

/* design/ldpcrow_back.sv */
`default_nettype none

module ldpcrow_back
    import ldpcrow_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int LLR_WIDTH  = LLR_WIDTH_DEF,
    localparam int MW = LLR_WIDTH - 1,
    localparam int AW = $clog2(MAX_DEGREE),
    localparam int CW = $clog2(MAX_DEGREE + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_empty,
    output logic                      o_pop,
    input  wire t_edge_ctl            i_ctl,
    input  wire logic [LLR_WIDTH-1:0] i_q,
    input  wire logic [MW-1:0]        i_min1,
    input  wire logic [MW-1:0]        i_min2,
    input  wire logic [AW-1:0]        i_pos,
    input  wire logic                 i_par,
    input  wire logic [CW-1:0]        i_cnt,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [LLR_WIDTH-1:0]      o_new_check_msg,
    output logic [LLR_WIDTH-1:0]      o_new_posterior,
    output logic                      o_last_out
);

    localparam logic [LLR_WIDTH-1:0] MAXV = {1'b0, {MW{1'b1}}};
    localparam logic [LLR_WIDTH-1:0] MINV = {1'b1, {MW{1'b0}}};

    typedef enum logic {
        S_LOAD,
        S_DRAIN
    } t_state;

    t_state r_state;

    logic [LLR_WIDTH-1:0] r_buf [MAX_DEGREE];
    logic [CW-1:0]        r_wr_cnt;
    logic [CW-1:0]        r_rd_idx;
    logic [CW-1:0]        r_n;
    logic [MW-1:0]        r_min1;
    logic [MW-1:0]        r_min2;
    logic [AW-1:0]        r_pos;
    logic                 r_par;

    // Read stage: buffer data plus the magnitude picked for that edge.
    logic                 r_s1_vld;
    logic [LLR_WIDTH-1:0] r_s1_q;
    logic [MW-1:0]        r_s1_mag;
    logic                 r_s1_par;
    logic                 r_s1_last;

    logic                 r_o_vld;
    logic [LLR_WIDTH-1:0] r_o_msg;
    logic [LLR_WIDTH-1:0] r_o_post;
    logic                 r_o_last;

    logic                 s2_take;
    logic                 s1_free;
    logic                 issue;
    logic                 issue_last;
    logic [LLR_WIDTH-1:0] mag_w;
    logic [LLR_WIDTH-1:0] msg;
    logic [LLR_WIDTH:0]   sum;
    logic [LLR_WIDTH-1:0] post;

    assign o_pop      = (r_state == S_LOAD) && !i_empty;
    assign s2_take    = r_s1_vld && (!r_o_vld || i_ready);
    assign s1_free    = !r_s1_vld || s2_take;
    assign issue      = (r_state == S_DRAIN) && s1_free;
    assign issue_last = ((r_rd_idx + CW'(1)) == r_n);

    assign mag_w = {1'b0, r_s1_mag};
    assign msg   = (r_s1_q[LLR_WIDTH-1] ^ r_s1_par) ? ('0 - mag_w) : mag_w;
    assign sum   = {r_s1_q[LLR_WIDTH-1], r_s1_q} + {msg[LLR_WIDTH-1], msg};

    always_comb begin
        if (sum[LLR_WIDTH] != sum[LLR_WIDTH-1]) begin
            post = sum[LLR_WIDTH] ? MINV : MAXV;
        end else begin
            post = sum[LLR_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_ctl.keep) begin
            r_buf[r_wr_cnt[AW-1:0]] <= i_q;
        end
        if (issue) begin
            r_s1_q <= r_buf[r_rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_wr_cnt <= '0;
            r_rd_idx <= '0;
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (o_pop) begin
                        if (i_ctl.last) begin
                            r_min1   <= i_min1;
                            r_min2   <= i_min2;
                            r_pos    <= i_pos;
                            r_par    <= i_par;
                            r_n      <= i_cnt;
                            r_rd_idx <= '0;
                            r_wr_cnt <= '0;
                            r_state  <= S_DRAIN;
                        end else if (i_ctl.keep) begin
                            r_wr_cnt <= r_wr_cnt + CW'(1);
                        end
                    end
                end
                S_DRAIN: begin
                    if (issue) begin
                        r_rd_idx <= r_rd_idx + CW'(1);
                        if (issue_last) begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase

            if (issue) begin
                r_s1_vld  <= 1'b1;
                r_s1_mag  <= (r_rd_idx[AW-1:0] == r_pos) ? r_min2 : r_min1;
                r_s1_par  <= r_par;
                r_s1_last <= issue_last;
            end else if (s2_take) begin
                r_s1_vld <= 1'b0;
            end

            if (s2_take) begin
                r_o_vld  <= 1'b1;
                r_o_msg  <= msg;
                r_o_post <= post;
                r_o_last <= r_s1_last;
            end else if (i_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    assign o_valid         = r_o_vld;
    assign o_new_check_msg = r_o_msg;
    assign o_new_posterior = r_o_post;
    assign o_last_out      = r_o_last;

    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && r_o_vld && !i_ready |=> r_s1_vld && $stable(r_s1_q))
        else $error("read stage lost its beat while the output was stalled");

    a_read_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> (r_rd_idx < r_n))
        else $error("buffer read beyond the row length");

    a_drain_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DRAIN |-> (r_n != '0) && (r_wr_cnt == '0))
        else $error("drain running with an empty row or a live write count");

    a_last_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue && issue_last |=> r_state == S_LOAD)
        else $error("drain did not end after the row's last read");

endmodule

`default_nettype wire

/* design/ldpc_layered_min_sum_row_update_core.sv */
`default_nettype none

// Check-node row update for a layered min-sum LDPC decoder. Each input beat is
// one edge of a parity-check row; the front end forms the saturated extrinsic
// value, tracks both minima, the minimum's position and the sign parity, and
// accepts one edge per cycle while the queue is not full into a queue of
// QUEUE_DEPTH entries. The back end moves queued edges into the single row
// buffer at one per cycle while it loads and the queue is not empty and,
// once the row's last edge arrives, drains one result beat per cycle while
// the output is not stalled, through a registered buffer read and an output
// register. Since the one buffer is first written and then read out, the
// back end takes no edge of the next row until the last buffer read of the
// row. While a row drains, the front end keeps taking edges of the next row
// until the queue is full. Edges beyond MAX_DEGREE are dropped, but a
// last-edge flag on them still closes the row.
module ldpc_layered_min_sum_row_update_core
    import ldpcrow_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int LLR_WIDTH  = LLR_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [LLR_WIDTH-1:0] i_posterior_llr,
    input  wire logic [LLR_WIDTH-1:0] i_old_check_msg,
    input  wire logic                 i_last_edge,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [LLR_WIDTH-1:0]      o_new_check_msg,
    output logic [LLR_WIDTH-1:0]      o_new_posterior,
    output logic                      o_last_out
);

    localparam int MW = LLR_WIDTH - 1;
    localparam int AW = $clog2(MAX_DEGREE);
    localparam int CW = $clog2(MAX_DEGREE + 1);
    localparam int DW = $bits(t_edge_ctl) + LLR_WIDTH + 2 * MW + AW + 1 + CW;

    logic             f_push;
    t_edge_ctl        f_ctl;
    logic [LLR_WIDTH-1:0] f_q;
    logic [MW-1:0]    f_min1;
    logic [MW-1:0]    f_min2;
    logic [AW-1:0]    f_pos;
    logic             f_par;
    logic [CW-1:0]    f_cnt;

    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic [DW-1:0]    q_wdata;
    logic [DW-1:0]    q_rdata;

    t_edge_ctl        b_ctl;
    logic [LLR_WIDTH-1:0] b_q;
    logic [MW-1:0]    b_min1;
    logic [MW-1:0]    b_min2;
    logic [AW-1:0]    b_pos;
    logic             b_par;
    logic [CW-1:0]    b_cnt;

    ldpcrow_front #(
        .MAX_DEGREE (MAX_DEGREE),
        .LLR_WIDTH  (LLR_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_posterior_llr (i_posterior_llr),
        .i_old_check_msg (i_old_check_msg),
        .i_last_edge     (i_last_edge),
        .i_full          (q_full),
        .o_push          (f_push),
        .o_ctl           (f_ctl),
        .o_q             (f_q),
        .o_min1          (f_min1),
        .o_min2          (f_min2),
        .o_pos           (f_pos),
        .o_par           (f_par),
        .o_cnt           (f_cnt)
    );

    assign q_wdata = {f_ctl, f_q, f_min1, f_min2, f_pos, f_par, f_cnt};

    ldpcrow_queue #(
        .DW    (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign {b_ctl, b_q, b_min1, b_min2, b_pos, b_par, b_cnt} = q_rdata;

    ldpcrow_back #(
        .MAX_DEGREE (MAX_DEGREE),
        .LLR_WIDTH  (LLR_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .o_pop           (q_pop),
        .i_ctl           (b_ctl),
        .i_q             (b_q),
        .i_min1          (b_min1),
        .i_min2          (b_min2),
        .i_pos           (b_pos),
        .i_par           (b_par),
        .i_cnt           (b_cnt),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_new_check_msg (o_new_check_msg),
        .o_new_posterior (o_new_posterior),
        .o_last_out      (o_last_out)
    );

endmodule

`default_nettype wire
